FILE: rtl/gise_pkg.sv
// shared types, constants and opcode values of the grey-map to sketch encoder
package gise_pkg;

    localparam int DIM_BITS = 16;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_MAXVAL = 3'd3,
        PH_PIXELS = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        ST_COLOR0   = 4'd0,
        ST_COLOR1   = 4'd1,
        ST_COLOR2   = 4'd2,
        ST_COLOR3   = 4'd3,
        ST_COLOR4   = 4'd4,
        ST_COLOR5   = 4'd5,
        ST_COLOR6   = 4'd6,
        ST_MOVE0    = 4'd7,
        ST_MOVE1    = 4'd8,
        ST_ROW0     = 4'd9,
        ST_ROW1     = 4'd10,
        ST_ROW2     = 4'd11,
        ST_ROW3     = 4'd12,
        ST_ROW4     = 4'd13,
        ST_ROW5     = 4'd14
    } t_step;

    localparam logic [7:0] MAGIC_COUNT = 8'd3;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam int         MAX_LEVELS  = 256;

    localparam logic [7:0] OP_COLOR_FULL = 8'hff;
    localparam logic [7:0] OP_COLOR_SET  = 8'h83;
    localparam logic [7:0] OP_STEP_A     = 8'h01;
    localparam logic [7:0] OP_STEP_B     = 8'h40;
    localparam logic [7:0] OP_ROW_A      = 8'h80;
    localparam logic [7:0] OP_ROW_B      = 8'h01;
    localparam logic [7:0] OP_ROW_C      = 8'h81;
    localparam logic [7:0] OP_ROW_D      = 8'h41;
    localparam logic [7:0] OP_ROW_E      = 8'hc0;
    localparam logic [7:0] OP_ROW_F      = 8'h84;

    typedef struct packed {
        logic [7:0] pixel;
        logic       color;
        logic       row_end;
    } t_run;

endpackage

FILE: rtl/gise_if.sv
// valid/ready channel interfaces for input bytes and sketch opcode bytes
interface gise_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface gise_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

FILE: rtl/gise_parser.sv
// header parser and per-pixel run decision with the encoder state
module gise_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output gise_pkg::t_run o_run
);
    import gise_pkg::*;

    localparam int AW = DIM_BITS + 6;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_skip, n_skip;
    logic [DIM_BITS-1:0]   r_width, n_width;
    logic [DIM_BITS-1:0]   r_height, n_height;
    logic [DIM_BITS-1:0]   r_max, n_max;
    logic [7:0]            r_prev, n_prev;
    logic [DIM_BITS-1:0]   r_col, n_col;

    logic                  delim;
    logic                  levels_ok;
    logic                  row_end;
    logic [DIM_BITS-1:0]   acc_src;
    logic [DIM_BITS-1:0]   acc_res;

    function automatic logic [DIM_BITS-1:0] accumulate(input logic [DIM_BITS-1:0] acc,
                                                      input logic [7:0] b);
        logic [AW-1:0] p;
        logic [AW-1:0] q;
        p = (AW'(acc) << 3) + (AW'(acc) << 1) + AW'(b);
        q = p - AW'(CH_ZERO);
        if (p < AW'(CH_ZERO))
            return '0;
        else if (|q[AW-1:DIM_BITS])
            return '1;
        else
            return q[DIM_BITS-1:0];
    endfunction

    assign delim     = (i_byte == CH_SPACE) || (i_byte == CH_LF) ||
                       (i_byte == CH_CR) || (i_byte == CH_TAB);
    assign levels_ok = 33'(r_max) < 33'(MAX_LEVELS);
    assign row_end   = (r_width != '0) && (r_col == r_width - 1'b1);

    always_comb begin
        unique case (r_phase)
            PH_WIDTH:  acc_src = r_width;
            PH_HEIGHT: acc_src = r_height;
            default:   acc_src = r_max;
        endcase
    end

    assign acc_res = accumulate(acc_src, i_byte);

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_width  = r_width;
        n_height = r_height;
        n_max    = r_max;
        n_prev   = r_prev;
        n_col    = r_col;
        o_push   = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (8'(r_skip) + 8'd1 >= MAGIC_COUNT) begin
                        n_skip  = '0;
                        n_phase = PH_WIDTH;
                    end else begin
                        n_skip = r_skip + 2'd1;
                    end
                end
                PH_WIDTH: begin
                    if (delim) n_phase = PH_HEIGHT;
                    else       n_width = acc_res;
                end
                PH_HEIGHT: begin
                    if (delim) n_phase  = PH_MAXVAL;
                    else       n_height = acc_res;
                end
                PH_MAXVAL: begin
                    if (delim) begin
                        n_prev  = i_byte;
                        n_phase = PH_PIXELS;
                    end else begin
                        n_max = acc_res;
                    end
                end
                default: begin
                    if (levels_ok) begin
                        o_push = 1'b1;
                        n_prev = i_byte;
                        if (r_width != '0)
                            n_col = row_end ? '0 : r_col + 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_run.pixel   = i_byte;
    assign o_run.color   = i_byte != r_prev;
    assign o_run.row_end = row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_MAGIC;
            r_skip   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_max    <= '0;
            r_prev   <= '0;
            r_col    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_width  <= n_width;
            r_height <= n_height;
            r_max    <= n_max;
            r_prev   <= n_prev;
            r_col    <= n_col;
        end
    end

endmodule

FILE: rtl/gise_emitter.sv
// run register, opcode sequencer and output register
module gise_emitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gise_pkg::t_run  i_run,
    output logic            o_run_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);
    import gise_pkg::*;

    logic       r_run_valid;
    t_run       r_run;
    t_step      r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       out_free;
    logic       advance;
    logic       at_end;
    t_step      end_step;

    function automatic logic [7:0] step_byte(input t_step s, input logic [7:0] b);
        unique case (s)
            ST_COLOR0: return {6'b110000, b[7:6]};
            ST_COLOR1: return {2'b11, b[5:0]};
            ST_COLOR2: return {2'b11, b[7:2]};
            ST_COLOR3: return {2'b11, b[1:0], b[7:4]};
            ST_COLOR4: return {2'b11, b[3:0], 2'b11};
            ST_COLOR5: return OP_COLOR_FULL;
            ST_COLOR6: return OP_COLOR_SET;
            ST_MOVE0:  return OP_STEP_A;
            ST_MOVE1:  return OP_STEP_B;
            ST_ROW0:   return OP_ROW_A;
            ST_ROW1:   return OP_ROW_B;
            ST_ROW2:   return OP_ROW_C;
            ST_ROW3:   return OP_ROW_D;
            ST_ROW4:   return OP_ROW_E;
            ST_ROW5:   return OP_ROW_F;
            default:   return '0;
        endcase
    endfunction

    assign end_step    = r_run.row_end ? ST_ROW5 : ST_MOVE1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_run_valid && out_free;
    assign at_end      = r_step == end_step;
    assign o_run_ready = !r_run_valid || (advance && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
        end else if (i_push) begin
            r_run_valid <= 1'b1;
        end else if (advance && at_end) begin
            r_run_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_run  <= i_run;
            r_step <= i_run.color ? ST_COLOR0 : ST_MOVE0;
        end else if (advance && !at_end) begin
            r_step <= t_step'(4'(r_step) + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_run_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= step_byte(r_step, r_run.pixel);
            r_out_last <= at_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

FILE: rtl/gray_image_to_sketch_encoder.sv
// top level of the grey-map to sketch opcode encoder
//   channel | dir | payload               | transfer when
//   i_in    | in  | in_byte[7:0]          | valid && ready
//   o_out   | out | out_byte, last_of_run | valid && ready
// header bytes cause no output; a pixel gives 2, 8, 9 or 15 opcode bytes (none when
// the max value is 256 or more), one per cycle while the output is not stalled
// a pixel run is held in one run register and walked by a 4-bit step counter; the next
// pixel is taken in the cycle its predecessor's last byte enters the output register
// synchronous active-low reset returns the parser to the magic bytes
// an output stall holds the output register and, behind it, the input
module gray_image_to_sketch_encoder (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gise_in_if.sink     i_in,
    gise_out_if.source  o_out
);
    import gise_pkg::*;

    logic run_ready;
    logic push;
    t_run run;

    assign i_in.ready = run_ready;

    gise_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (i_in.valid && run_ready),
        .i_byte  (i_in.in_byte),
        .o_push  (push),
        .o_run   (run)
    );

    gise_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_run       (run),
        .o_run_ready (run_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last_of_run)
    );

endmodule

FILE: rtl/gise_checker.sv
// port-level assertions for the encoder and their binding
module gise_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last
);
    import gise_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside an opcode run");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=>
            !i_out_valid || i_out_byte == OP_STEP_A || i_out_byte[7:6] == 2'b11)
        else $error("run starts with an unexpected opcode");

endmodule

bind gray_image_to_sketch_encoder gise_checker u_gise_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);
